### sv/hmll_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmll_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_EMPHASIS_MODE = 3'd0;
   localparam logic [2:0] CSR_FG_COEF       = 3'd1;
   localparam logic [2:0] CSR_BG_COEF       = 3'd2;
   localparam logic [2:0] CSR_GRAD_SCALE    = 3'd3;
   localparam logic [2:0] CSR_BATCH_RECIP   = 3'd4;
   localparam logic [2:0] CSR_PASS_ENABLE   = 3'd5;

   // emphasis modes
   localparam logic [2:0] MODE_NONE        = 3'd0;
   localparam logic [2:0] MODE_TRUTH_ONLY  = 3'd1;
   localparam logic [2:0] MODE_SCALE_FG    = 3'd2;
   localparam logic [2:0] MODE_SAMPLE_BG   = 3'd3;
   localparam logic [2:0] MODE_SAMPLE_BGFG = 3'd4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef struct packed {
      logic [2:0]         emphasis_mode;
      logic [15:0]        fg_coef;
      logic [15:0]        bg_coef;
      logic signed [15:0] grad_scale;
      logic [15:0]        batch_recip;
      logic [1:0]         pass_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODE,
      ST_WEIGHT,
      ST_SCALE,
      ST_LOSS_LO,
      ST_LOSS_HI,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_LOAD,
      STEP_MODE,
      STEP_WEIGHT,
      STEP_SCALE,
      STEP_LOSS_LO,
      STEP_LOSS_HI,
      STEP_OUT
   } step_type;

   typedef struct packed {
      step_type step;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_sts_type;

endpackage

`default_nettype wire

### sv/hmll_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hmll_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] predicted;
   logic signed [15:0] truth;
   logic               keep_sample;
   logic [15:0]        map_weight;
   logic               batch_end;

   modport source (output valid, predicted, truth, keep_sample, map_weight, batch_end,
                   input ready);
   modport sink   (input valid, predicted, truth, keep_sample, map_weight, batch_end,
                   output ready);
endinterface

`default_nettype wire

### sv/hmll_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hmll_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] grad_pred;
   logic signed [15:0] grad_truth;
   logic [47:0]        scaled_loss;
   logic               loss_valid;

   modport source (output valid, grad_pred, grad_truth, scaled_loss, loss_valid,
                   input ready);
   modport sink   (input valid, grad_pred, grad_truth, scaled_loss, loss_valid,
                   output ready);
endinterface

`default_nettype wire

### sv/hmll_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module hmll_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [hmll_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hmll_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output hmll_pkg::cfg_type                       cfg
);
   import hmll_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_EMPHASIS_MODE: cfg_in.emphasis_mode = csr_wdata[2:0];
            CSR_FG_COEF:       cfg_in.fg_coef       = csr_wdata;
            CSR_BG_COEF:       cfg_in.bg_coef       = csr_wdata;
            CSR_GRAD_SCALE:    cfg_in.grad_scale    = csr_wdata;
            CSR_BATCH_RECIP:   cfg_in.batch_recip   = csr_wdata;
            CSR_PASS_ENABLE:   cfg_in.pass_enable   = csr_wdata[1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.emphasis_mode <= MODE_NONE;
         cfg_ff.fg_coef       <= 16'd4096;
         cfg_ff.bg_coef       <= 16'd4096;
         cfg_ff.grad_scale    <= 16'sd4096;
         cfg_ff.batch_recip   <= 16'hFFFF;
         cfg_ff.pass_enable   <= 2'b11;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### sv/hmll_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hmll_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire hmll_pkg::dp_sts_type sts,
   output hmll_pkg::dp_cmd_type      cmd
);
   import hmll_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.step     = STEP_IDLE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.step = STEP_LOAD;
               state_in = ST_MODE;
            end
         end
         ST_MODE: begin
            cmd.step = STEP_MODE;
            state_in = ST_WEIGHT;
         end
         ST_WEIGHT: begin
            cmd.step = STEP_WEIGHT;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.step = STEP_SCALE;
            state_in = sts.last ? ST_LOSS_LO : ST_OUT;
         end
         ST_LOSS_LO: begin
            cmd.step = STEP_LOSS_LO;
            state_in = ST_LOSS_HI;
         end
         ST_LOSS_HI: begin
            cmd.step = STEP_LOSS_HI;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // output register free or emptied this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.step     = STEP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts_mode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (cmd.step == STEP_MODE))
      else $error("accepted element did not enter the mode step");

   a_last_runs_loss: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_SCALE && sts.last) |=> (cmd.step == STEP_LOSS_LO))
      else $error("batch end skipped the loss steps");

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_OUT) |=> rsp_valid_ff)
      else $error("result load did not raise rsp valid");
`endif

endmodule

`default_nettype wire

### sv/hmll_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hmll_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire hmll_pkg::cfg_type    cfg,
   input  wire hmll_pkg::dp_cmd_type cmd,
   output hmll_pkg::dp_sts_type      sts,
   input  wire logic signed [15:0]   predicted,
   input  wire logic signed [15:0]   truth,
   input  wire logic                 keep_sample,
   input  wire logic [15:0]          map_weight,
   input  wire logic                 batch_end,
   output logic signed [15:0]        grad_pred,
   output logic signed [15:0]        grad_truth,
   output logic [47:0]               scaled_loss,
   output logic                      loss_valid
);
   import hmll_pkg::*;

   localparam logic [47:0] SUM_MAX = '1;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -32'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // element registers
   logic signed [16:0] diff_ff;
   logic               fg_ff;
   logic               keep_ff;
   logic [15:0]        weight_ff;
   logic               last_ff;
   // work registers
   logic [31:0]        sq_ff;
   logic [31:0]        sq_in;
   logic signed [30:0] g_ff;
   logic signed [30:0] g_in;
   logic [47:0]        sum_ff;
   logic [47:0]        sum_in;
   logic [23:0]        lacc_ff;
   logic [47:0]        loss_ff;
   // output register
   logic signed [15:0] grad_pred_ff;
   logic signed [15:0] grad_truth_ff;
   logic [47:0]        scaled_loss_ff;
   logic               loss_valid_ff;

   // shared multiplier
   logic signed [25:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [42:0] mul_p;
   logic signed [42:0] mul_r;

   logic               mode_mul;
   logic               mode_zero;
   logic [15:0]        mode_coef;
   logic [15:0]        mag;
   logic [48:0]        sum_add;
   logic signed [31:0] g_neg;

   // mode masking decision
   always_comb begin
      mode_mul  = 1'b0;
      mode_zero = 1'b0;
      mode_coef = cfg.fg_coef;
      case (cfg.emphasis_mode)
         MODE_TRUTH_ONLY: begin
            mode_zero = !fg_ff;
         end
         MODE_SCALE_FG: begin
            mode_mul = fg_ff;
         end
         MODE_SAMPLE_BG, MODE_SAMPLE_BGFG: begin
            if (fg_ff) begin
               mode_mul = (cfg.emphasis_mode == MODE_SAMPLE_BGFG);
            end else if (keep_ff) begin
               mode_mul  = 1'b1;
               mode_coef = cfg.bg_coef;
            end else begin
               mode_zero = 1'b1;
            end
         end
         default: begin
            mode_mul = 1'b0;
         end
      endcase
   end

   always_comb begin
      mul_a = g_ff[25:0];
      mul_b = {1'b0, weight_ff};
      case (cmd.step)
         STEP_MODE: begin
            mul_a = {{9{diff_ff[16]}}, diff_ff};
            mul_b = {1'b0, mode_coef};
         end
         STEP_SCALE: begin
            mul_b = {cfg.grad_scale[15], cfg.grad_scale};
         end
         STEP_LOSS_LO: begin
            mul_a = {2'b00, sum_ff[23:0]};
            mul_b = {1'b0, cfg.batch_recip};
         end
         STEP_LOSS_HI: begin
            mul_a = {2'b00, sum_ff[47:24]};
            mul_b = {1'b0, cfg.batch_recip};
         end
         default: begin
            mul_b = {1'b0, weight_ff};
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   // Q4.12 result: add half an lsb, then floor through the shift
   assign mul_r = mul_p + 43'sd2048;

   // magnitude of the 17-bit difference fits 16 bits
   assign mag     = diff_ff[16] ? 16'(-diff_ff) : diff_ff[15:0];
   assign sq_in   = 32'(mag * mag);
   assign sum_add = {1'b0, sum_ff} + {17'd0, sq_ff};
   assign g_neg   = -32'(g_ff);

   always_comb begin
      g_in   = g_ff;
      sum_in = sum_ff;
      case (cmd.step)
         STEP_MODE: begin
            if (mode_zero) begin
               g_in = '0;
            end else if (mode_mul) begin
               g_in = mul_r[42:12];
            end else begin
               g_in = {{14{diff_ff[16]}}, diff_ff};
            end
         end
         STEP_WEIGHT: begin
            g_in   = mul_r[42:12];
            sum_in = sum_add[48] ? SUM_MAX : sum_add[47:0];
         end
         STEP_SCALE: begin
            g_in = mul_r[42:12];
         end
         STEP_LOSS_HI: begin
            sum_in = '0;
         end
         default: begin
            g_in = g_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      g_ff <= g_in;
      if (cmd.step == STEP_LOAD) begin
         diff_ff   <= 17'(predicted) - 17'(truth);
         fg_ff     <= (truth != 16'sd0);
         keep_ff   <= keep_sample;
         weight_ff <= map_weight;
         last_ff   <= batch_end;
      end
      if (cmd.step == STEP_MODE) begin
         sq_ff <= sq_in;
      end
      if (cmd.step == STEP_LOSS_LO) begin
         lacc_ff <= mul_p[39:16];
      end
      if (cmd.step == STEP_LOSS_HI) begin
         loss_ff <= {mul_p[39:0], 8'd0} + {24'd0, lacc_ff};
      end
      if (cmd.step == STEP_OUT) begin
         grad_pred_ff   <= cfg.pass_enable[0] ? sat16(32'(g_ff)) : 16'sd0;
         grad_truth_ff  <= cfg.pass_enable[1] ? sat16(g_neg) : 16'sd0;
         scaled_loss_ff <= last_ff ? loss_ff : 48'd0;
         loss_valid_ff  <= last_ff;
      end
   end

   assign sts.last    = last_ff;
   assign grad_pred   = grad_pred_ff;
   assign grad_truth  = grad_truth_ff;
   assign scaled_loss = scaled_loss_ff;
   assign loss_valid  = loss_valid_ff;

`ifndef SYNTHESIS
   a_sum_never_wraps: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_WEIGHT) |=> (sum_ff >= $past(sum_ff)))
      else $error("square sum wrapped");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_LOSS_HI) |=> (sum_ff == 48'd0))
      else $error("square sum not cleared at batch end");

   a_loss_zero_mid_batch: assert property (@(posedge clock) disable iff (reset)
      (cmd.step == STEP_OUT && !last_ff) |=> (scaled_loss == 48'd0 && !loss_valid))
      else $error("loss reported before batch end");
`endif

endmodule

`default_nettype wire

### sv/heatmap_masked_l2_loss.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          predicted, truth, keep_sample, map_weight, batch_end
// rsp_ch    out  valid/ready          grad_pred, grad_truth, scaled_loss, loss_valid
// csr_*     in   csr_we (no stall)    csr_index, csr_wdata
//
// One element in flight. An element passes from accept to result load through the
// accept, mode, weight, scale and load steps, plus the loss_lo and loss_hi steps on a
// batch_end element for the two halves of the loss multiply; the gradient and loss
// steps share one 26x17 signed multiplier, the square has its own 16x16.
// Reset is synchronous: config returns to defaults, the square sum to zero.
// The result register lets the next element be accepted and computed while a
// result waits; a stalled rsp only holds the load step.

module heatmap_masked_l2_loss (
   input  wire logic                             clock,
   input  wire logic                             reset,
   hmll_req_if.sink                              req_ch,
   hmll_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [hmll_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hmll_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hmll_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   // register file; write it only while idle, the block itself does not enforce this
   hmll_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: steps the datapath, owns both handshakes
   hmll_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // difference, square sum, gradient chain, loss and result register
   hmll_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .predicted   (req_ch.predicted),
      .truth       (req_ch.truth),
      .keep_sample (req_ch.keep_sample),
      .map_weight  (req_ch.map_weight),
      .batch_end   (req_ch.batch_end),
      .grad_pred   (rsp_ch.grad_pred),
      .grad_truth  (rsp_ch.grad_truth),
      .scaled_loss (rsp_ch.scaled_loss),
      .loss_valid  (rsp_ch.loss_valid)
   );

endmodule

`default_nettype wire
